// ===== hw/rtl/least_loaded_dispatch_unit_macros.svh =====
// Assertion macros shared by the dispatch unit RTL.
// The implication form checks the consequent in the same cycle, the next-cycle
// form checks it in the cycle after. Both are disabled while reset is high.
`ifndef LEAST_LOADED_DISPATCH_UNIT_MACROS_SVH
`define LEAST_LOADED_DISPATCH_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define LLD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define LLD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define LLD_ASSERT_IMP(label, clk, rst, ante, cons, msg)

`define LLD_ASSERT_NXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/lld_pkg.sv =====
package lld_pkg;

   // Size of the counter bank and the widths that follow from it.
   localparam int MAX_COUNTERS = 16;
   localparam int IDX_W        = $clog2(MAX_COUNTERS);

   // Fixed field widths of the words on the ports.
   localparam int TIME_W          = 16;
   localparam int LOAD_W          = 32;
   localparam int WAIT_W          = 48;
   localparam int COUNTER_INDEX_W = 4;
   localparam int CSR_W           = 5;
   localparam int ALU_W           = WAIT_W;

   localparam int REQ_TDATA_W  = TIME_W;
   localparam int RSP_FIELDS_W = COUNTER_INDEX_W + 2 * LOAD_W + WAIT_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_TDATA_W - RSP_FIELDS_W;

   // Number of active counters after reset.
   localparam logic [CSR_W-1:0] CSR_RESET = 5'd16;

   // Operations of the shared arithmetic unit.
   typedef enum logic [1:0] {
      ALU_LESS,
      ALU_ADD_LOAD,
      ALU_ADD_WAIT
   } alu_op_type;

   // Command from the sequencer to the load bank.
   typedef struct packed {
      logic              clr;
      logic              wr_en;
      logic [IDX_W-1:0]  wr_idx;
      logic [LOAD_W-1:0] wr_data;
   } bank_cmd_type;

   // Layout of the result word, lowest field last.
   typedef struct packed {
      logic [RSP_PAD_W-1:0]       pad;
      logic [WAIT_W-1:0]          total_wait;
      logic [LOAD_W-1:0]          makespan;
      logic [LOAD_W-1:0]          finish_time;
      logic [COUNTER_INDEX_W-1:0] counter_index;
   } rsp_word_type;

endpackage

// ===== hw/rtl/lld_alu.sv =====
module lld_alu (
   input  lld_pkg::alu_op_type       op,
   input  logic [lld_pkg::ALU_W-1:0] a,
   input  logic [lld_pkg::ALU_W-1:0] b,
   output logic [lld_pkg::ALU_W-1:0] res,
   output logic                      less
);

   logic [lld_pkg::ALU_W:0] sum;

   // One wide adder and one comparator, shared by every step of the sequencer.
   assign sum  = {1'b0, a} + {1'b0, b};
   assign less = (a < b);

   // Saturate the sum at the width that the operation asks for.
   always_comb begin
      unique case (op)
         lld_pkg::ALU_ADD_WAIT: begin
            res = sum[lld_pkg::ALU_W] ? '1 : sum[lld_pkg::ALU_W-1:0];
         end
         lld_pkg::ALU_ADD_LOAD: begin
            if (sum[lld_pkg::ALU_W:lld_pkg::LOAD_W] != '0) begin
               res = lld_pkg::ALU_W'({lld_pkg::LOAD_W{1'b1}});
            end else begin
               res = sum[lld_pkg::ALU_W-1:0];
            end
         end
         lld_pkg::ALU_LESS: begin
            res = '0;
         end
         default: begin
            res = '0;
         end
      endcase
   end

endmodule

// ===== hw/rtl/lld_load_bank.sv =====
module lld_load_bank (
   input  logic                              clock,
   input  logic                              reset,
   input  lld_pkg::bank_cmd_type             cmd,
   input  logic [lld_pkg::IDX_W-1:0]         rd_idx,
   output logic [lld_pkg::LOAD_W-1:0]        rd_load,
   output logic                              rd_used
);

   logic [lld_pkg::LOAD_W-1:0]       load_ff [lld_pkg::MAX_COUNTERS];
   logic [lld_pkg::LOAD_W-1:0]       load_in [lld_pkg::MAX_COUNTERS];
   logic [lld_pkg::MAX_COUNTERS-1:0] used_ff;
   logic [lld_pkg::MAX_COUNTERS-1:0] used_in;

   // A counter that has not received a job in this batch reads as zero load.
   assign rd_used = used_ff[rd_idx];
   assign rd_load = used_ff[rd_idx] ? load_ff[rd_idx] : '0;

   // A batch clear drops the used flags; a write stores a load and marks it used.
   always_comb begin
      load_in = load_ff;
      used_in = used_ff;
      if (cmd.clr) begin
         used_in = '0;
      end else if (cmd.wr_en) begin
         load_in[cmd.wr_idx] = cmd.wr_data;
         used_in[cmd.wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      load_ff <= load_in;
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

endmodule

// ===== hw/rtl/least_loaded_dispatch_unit.sv =====
// Channel   Direction  Word contents (lowest bit first)
// req_      in         tdata: proc_time[15:0]; tuser: first_job
// rsp_      out        tdata: counter_index, finish_time, makespan, total_wait, zero pad
// csr_      in         wdata: counters_in_use[4:0], written when csr_wen is high
//
// A job passes an accept state, a scan state that visits the active counters in turn
// (stopping early when an unused counter turns up), the wait, load and makespan
// update states and an output state that holds until rsp_tready.
// The single shared adder and comparator visits the counters one per cycle.
// Reset zeroes the makespan, waiting total and used flags; 16 counters are active.
// The result stays in the output register until rsp_tready; no new job is taken meanwhile.
`include "least_loaded_dispatch_unit_macros.svh"

module least_loaded_dispatch_unit (
   input  logic                                clock,
   input  logic                                reset,
   // Job words: tdata = proc_time[15:0]; tuser = first_job.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lld_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic [0:0]                          req_tuser,
   // Result words: tdata = counter_index[3:0], finish_time[35:4],
   // makespan[67:36], total_wait[115:68], zero pad[119:116].
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [lld_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // Number of counters that take part in dispatch.
   input  logic                                csr_wen,
   input  logic [lld_pkg::CSR_W-1:0]           csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_WAIT,
      S_LOAD,
      S_MAX,
      S_OUT
   } state_type;

   state_type                       state_ff, state_in;
   logic [lld_pkg::CSR_W-1:0]       csr_ff, csr_in;
   logic [lld_pkg::TIME_W-1:0]      time_ff, time_in;
   logic [lld_pkg::IDX_W-1:0]       idx_ff, idx_in;
   logic [lld_pkg::IDX_W-1:0]       last_ff, last_in;
   logic [lld_pkg::IDX_W-1:0]       best_idx_ff, best_idx_in;
   logic [lld_pkg::LOAD_W-1:0]      best_load_ff, best_load_in;
   logic [lld_pkg::LOAD_W-1:0]      upd_ff, upd_in;
   logic [lld_pkg::LOAD_W-1:0]      max_ff, max_in;
   logic [lld_pkg::WAIT_W-1:0]      wait_ff, wait_in;

   logic [lld_pkg::IDX_W-1:0]       active_last;
   lld_pkg::bank_cmd_type           bank_cmd;
   logic [lld_pkg::LOAD_W-1:0]      rd_load;
   logic                            rd_used;
   lld_pkg::alu_op_type             alu_op;
   logic [lld_pkg::ALU_W-1:0]       alu_a;
   logic [lld_pkg::ALU_W-1:0]       alu_b;
   logic [lld_pkg::ALU_W-1:0]       alu_res;
   logic                            alu_less;
   lld_pkg::rsp_word_type           rsp_word;

   lld_load_bank u_bank (
      .clock   (clock),
      .reset   (reset),
      .cmd     (bank_cmd),
      .rd_idx  (idx_ff),
      .rd_load (rd_load),
      .rd_used (rd_used)
   );

   lld_alu u_alu (
      .op   (alu_op),
      .a    (alu_a),
      .b    (alu_b),
      .res  (alu_res),
      .less (alu_less)
   );

   // Highest active counter index; zero acts as one, too many acts as the bank size.
   always_comb begin
      if (csr_ff == '0) begin
         active_last = '0;
      end else if (32'(csr_ff) > lld_pkg::MAX_COUNTERS) begin
         active_last = lld_pkg::IDX_W'(lld_pkg::MAX_COUNTERS - 1);
      end else begin
         active_last = lld_pkg::IDX_W'(csr_ff - lld_pkg::CSR_W'(1));
      end
   end

   // Handshake and result word come straight from the registers.
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);

   assign rsp_word.pad           = '0;
   assign rsp_word.total_wait    = wait_ff;
   assign rsp_word.makespan      = max_ff;
   assign rsp_word.finish_time   = upd_ff;
   assign rsp_word.counter_index = lld_pkg::COUNTER_INDEX_W'(best_idx_ff);
   assign rsp_tdata              = rsp_word;

   // Sequencer: scan the counters, then add the wait, add the load and update the makespan in turn.
   always_comb begin
      state_in     = state_ff;
      csr_in       = csr_wen ? csr_wdata : csr_ff;
      time_in      = time_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      best_idx_in  = best_idx_ff;
      best_load_in = best_load_ff;
      upd_in       = upd_ff;
      max_in       = max_ff;
      wait_in      = wait_ff;
      bank_cmd     = '0;
      alu_op       = lld_pkg::ALU_LESS;
      alu_a        = lld_pkg::ALU_W'(rd_load);
      alu_b        = lld_pkg::ALU_W'(best_load_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               time_in  = req_tdata[lld_pkg::TIME_W-1:0];
               idx_in   = '0;
               last_in  = active_last;
               state_in = S_SCAN;
               if (req_tuser[0]) begin
                  bank_cmd.clr = 1'b1;
                  max_in       = '0;
                  wait_in      = '0;
               end
            end
         end
         S_SCAN: begin
            // The first unused counter wins at once; otherwise keep the strict minimum.
            if (!rd_used) begin
               best_idx_in  = idx_ff;
               best_load_in = '0;
               state_in     = S_WAIT;
            end else begin
               if (idx_ff == '0 || alu_less) begin
                  best_idx_in  = idx_ff;
                  best_load_in = rd_load;
               end
               if (idx_ff == last_ff) begin
                  state_in = S_WAIT;
               end else begin
                  idx_in = idx_ff + lld_pkg::IDX_W'(1);
               end
            end
         end
         S_WAIT: begin
            alu_op   = lld_pkg::ALU_ADD_WAIT;
            alu_a    = wait_ff;
            alu_b    = lld_pkg::ALU_W'(best_load_ff);
            wait_in  = alu_res;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            alu_op           = lld_pkg::ALU_ADD_LOAD;
            alu_a            = lld_pkg::ALU_W'(best_load_ff);
            alu_b            = lld_pkg::ALU_W'(time_ff);
            upd_in           = alu_res[lld_pkg::LOAD_W-1:0];
            bank_cmd.wr_en   = 1'b1;
            bank_cmd.wr_idx  = best_idx_ff;
            bank_cmd.wr_data = alu_res[lld_pkg::LOAD_W-1:0];
            state_in         = S_MAX;
         end
         S_MAX: begin
            alu_op = lld_pkg::ALU_LESS;
            alu_a  = lld_pkg::ALU_W'(max_ff);
            alu_b  = lld_pkg::ALU_W'(upd_ff);
            if (alu_less) begin
               max_in = upd_ff;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      time_ff      <= time_in;
      idx_ff       <= idx_in;
      last_ff      <= last_in;
      best_idx_ff  <= best_idx_in;
      best_load_ff <= best_load_in;
      upd_ff       <= upd_in;
      if (reset) begin
         state_ff <= S_IDLE;
         csr_ff   <= lld_pkg::CSR_RESET;
         max_ff   <= '0;
         wait_ff  <= '0;
      end else begin
         state_ff <= state_in;
         csr_ff   <= csr_in;
         max_ff   <= max_in;
         wait_ff  <= wait_in;
      end
   end

   // The best counter so far always lies below the one being scanned.
   `LLD_ASSERT_IMP(a_scan_order, clock, reset, (state_ff == S_SCAN && idx_ff != '0), (best_idx_ff < idx_ff), "best counter not below scan index")
   // The scan never leaves the active counters.
   `LLD_ASSERT_IMP(a_scan_bound, clock, reset, (state_ff == S_SCAN), (idx_ff <= last_ff), "scan index beyond active counters")
   // A job that opens a batch starts from an empty makespan and waiting total.
   `LLD_ASSERT_NXT(a_batch_clear, clock, reset, (req_tvalid && req_tready && req_tuser[0]), (max_ff == '0 && wait_ff == '0), "batch totals not cleared")
   // Once the makespan step is done the result is offered and covers the new load.
   `LLD_ASSERT_NXT(a_makespan, clock, reset, (state_ff == S_MAX), (rsp_tvalid && max_ff >= upd_ff), "makespan below finish time")

endmodule
